// File: hdl/bpg_pkg.sv
// Package for the branch penalty block with target-register gap counters.
// Holds instruction function codes, field widths, parameter defaults and shared types.
// No dependencies.
package bpg_pkg;

  // Instruction function codes
  localparam logic [1:0] FUNC_SET_TR  = 2'd0;
  localparam logic [1:0] FUNC_UNCOND  = 2'd1;
  localparam logic [1:0] FUNC_COND    = 2'd2;
  localparam logic [1:0] FUNC_OTHER   = 2'd3;

  // Fixed field widths
  localparam int FUNC_W = 2;
  localparam int TREG_W = 3;
  localparam int ADDR_W = 3;
  localparam int PEN_W  = 3;

  // Parameter defaults
  localparam int GAP_LIMIT_DEF   = 7;
  localparam int TARGET_REGS_DEF = 8;

  // One registered instruction
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TREG_W-1:0] target_reg;
    logic              likely_hint;
    logic              taken;
    logic [ADDR_W-1:0] pc_low_bits;
    logic [ADDR_W-1:0] target_low_bits;
  } bpg_item_t;

  // Counter bank update control
  typedef struct packed {
    logic              step;    // advance all counters
    logic              set_en;  // clear the selected counter
    logic [TREG_W-1:0] set_reg;
  } bpg_upd_t;

endpackage

// File: hdl/bpg_gap_bank.sv
// Bank of saturating gap counters, one per branch target register.
// Depends on bpg_pkg.
module bpg_gap_bank
  import bpg_pkg::*;
#(
  parameter int GAP_LIMIT   = GAP_LIMIT_DEF,
  parameter int TARGET_REGS = TARGET_REGS_DEF,
  parameter int GAP_W       = $clog2(GAP_LIMIT + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TREG_W-1:0] rd_reg,
  output logic [GAP_W-1:0]  rd_gap,
  input  bpg_upd_t          upd
);

  localparam int CMP_W = 8;

  logic [GAP_W-1:0] gap_r   [TARGET_REGS];
  logic [GAP_W-1:0] gap_nxt [TARGET_REGS];

  // Read port: out-of-range registers read as the limit
  always_comb begin
    rd_gap = GAP_W'(GAP_LIMIT);
    for (int i = 0; i < TARGET_REGS; i++) begin
      if (CMP_W'(rd_reg) == CMP_W'(i)) begin
        rd_gap = gap_r[i];
      end
    end
  end

  // Next counter values: saturating advance, set clears its own counter
  always_comb begin
    for (int i = 0; i < TARGET_REGS; i++) begin
      gap_nxt[i] = gap_r[i];
      if (upd.step) begin
        if (upd.set_en && (CMP_W'(upd.set_reg) == CMP_W'(i))) begin
          gap_nxt[i] = '0;
        end else if (gap_r[i] != GAP_W'(GAP_LIMIT)) begin
          gap_nxt[i] = gap_r[i] + GAP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TARGET_REGS; i++) begin
      if (!rst_n) begin
        gap_r[i] <= GAP_W'(GAP_LIMIT);
      end else begin
        gap_r[i] <= gap_nxt[i];
      end
    end
  end

endmodule

// File: hdl/bpg_penalty.sv
// Combinational penalty calculation for one retired instruction.
// Depends on bpg_pkg.
module bpg_penalty
  import bpg_pkg::*;
#(
  parameter int GAP_W = $clog2(GAP_LIMIT_DEF + 1)
) (
  input  bpg_item_t         item,
  input  logic [GAP_W-1:0]  gap,
  input  logic              opt_mode,
  output logic [PEN_W-1:0]  penalty
);

  logic             pc_al;
  logic             tg_al;
  logic [PEN_W-1:0] gap_amt;

  assign pc_al = (item.pc_low_bits == '0);
  assign tg_al = (item.target_low_bits == '0);

  // Gap-based amount
  always_comb begin
    if (gap <= GAP_W'(1)) begin
      gap_amt = PEN_W'(2);
    end else if (gap == GAP_W'(2)) begin
      gap_amt = pc_al ? PEN_W'(1) : PEN_W'(2);
    end else if (gap == GAP_W'(3)) begin
      gap_amt = (tg_al && pc_al) ? PEN_W'(0) : PEN_W'(1);
    end else if (gap == GAP_W'(4)) begin
      gap_amt = (!tg_al && !pc_al) ? PEN_W'(1) : PEN_W'(0);
    end else begin
      gap_amt = '0;
    end
  end

  // Penalty by instruction kind
  always_comb begin
    penalty = '0;
    unique case (item.func)
      FUNC_UNCOND: begin
        penalty = item.likely_hint ? (gap_amt + PEN_W'(1)) : PEN_W'(3);
      end
      FUNC_COND: begin
        if (!item.taken) begin
          penalty = opt_mode ? PEN_W'(2) : PEN_W'(0);
        end else if (!item.likely_hint) begin
          penalty = opt_mode ? PEN_W'(2) : PEN_W'(5);
        end else if (!opt_mode) begin
          penalty = ((gap == GAP_W'(1)) && !pc_al) ? PEN_W'(3) : PEN_W'(2);
        end else begin
          penalty = gap_amt;
        end
      end
      FUNC_SET_TR, FUNC_OTHER: begin
        penalty = '0;
      end
      default: begin
        penalty = '0;
      end
    endcase
  end

endmodule

// File: hdl/branch_penalty_with_target_gap.sv
// Top level of the branch penalty block with per-target-register gap counters.
// Depends on bpg_pkg, bpg_gap_bank and bpg_penalty.
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   input    | in_valid/in_ready + 6 fields       | request in
//   result   | out_valid/out_ready + penalty      | request out
//   config   | cfg_wr_en/cfg_wr_data              | write only
//
// One request per cycle sustained without stalls; requests pass the input
// register, then the result register. Penalty and counter update are computed
// in the single stage between them. Synchronous active-low reset sets all gap
// counters to the limit and the mode to off. A stalled result holds the
// stage behind it; the input register still refills as soon as it moves.
module branch_penalty_with_target_gap
  import bpg_pkg::*;
#(
  parameter int GAP_LIMIT   = GAP_LIMIT_DEF,
  parameter int TARGET_REGS = TARGET_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [TREG_W-1:0] in_target_reg,
  input  logic              in_likely_hint,
  input  logic              in_taken,
  input  logic [ADDR_W-1:0] in_pc_low_bits,
  input  logic [ADDR_W-1:0] in_target_low_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PEN_W-1:0]  out_penalty_cycles
);

  localparam int GAP_W = $clog2(GAP_LIMIT + 1);

  logic             mode_r;
  bpg_item_t        item_r;
  logic             item_vld_r;
  logic             out_vld_r;
  logic [PEN_W-1:0] pen_r;
  logic             out_free;
  logic             advance;
  logic [GAP_W-1:0] gap;
  logic [PEN_W-1:0] pen_nxt;
  bpg_upd_t         upd;

  // Handshake
  assign out_free = !out_vld_r || out_ready;
  assign advance  = item_vld_r && out_free;
  assign in_ready = !item_vld_r || advance;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func            <= in_func;
      item_r.target_reg      <= in_target_reg;
      item_r.likely_hint     <= in_likely_hint;
      item_r.taken           <= in_taken;
      item_r.pc_low_bits     <= in_pc_low_bits;
      item_r.target_low_bits <= in_target_low_bits;
    end
  end

  // Counter bank, updated as the request leaves the input register
  assign upd.step    = advance;
  assign upd.set_en  = (item_r.func == FUNC_SET_TR);
  assign upd.set_reg = item_r.target_reg;

  bpg_gap_bank #(
    .GAP_LIMIT   (GAP_LIMIT),
    .TARGET_REGS (TARGET_REGS),
    .GAP_W       (GAP_W)
  ) u_gap_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_reg (item_r.target_reg),
    .rd_gap (gap),
    .upd    (upd)
  );

  bpg_penalty #(
    .GAP_W (GAP_W)
  ) u_penalty (
    .item     (item_r),
    .gap      (gap),
    .opt_mode (mode_r),
    .penalty  (pen_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pen_r <= pen_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_penalty_cycles = pen_r;

endmodule
